[rtl/tlba_pkg.sv]
// ----------------------------------------------------------------------------
// tlba_pkg
// shared constants, types and helpers of the two-level bitmap slot allocator
// ----------------------------------------------------------------------------
package tlba_pkg;

  localparam int PAGE_COUNT     = 32;
  localparam int SLOTS_PER_PAGE = 8;
  localparam int USABLE_PAGES   = (PAGE_COUNT < 32) ? PAGE_COUNT : 32;
  localparam int GROUPS         = (USABLE_PAGES + 7) / 8;
  localparam int SUM_BITS       = GROUPS * 8;
  localparam int PAGE_W         = $clog2(SUM_BITS);
  localparam int GRP_W          = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RANGE = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] slot;
  } req_t;

  // pages past the usable range read as full
  function automatic logic [SUM_BITS-1:0] sum_pad();
    logic [SUM_BITS-1:0] pad;
    for (int i = 0; i < SUM_BITS; i++) begin
      pad[i] = (i >= USABLE_PAGES);
    end
    return pad;
  endfunction

  // lowest clear bit of a byte
  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/tlba_if.sv]
// ----------------------------------------------------------------------------
// tlba_if
// request and result channels of the slot allocator
// ----------------------------------------------------------------------------
interface tlba_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] free_slot;

  modport source (output valid, func, free_slot, input ready);
  modport sink   (input valid, func, free_slot, output ready);
endinterface

interface tlba_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot;
  logic [1:0] status;

  modport source (output valid, slot, status, input ready);
  modport sink   (input valid, slot, status, output ready);
endinterface

[rtl/two_level_bitmap_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// two_level_bitmap_slot_allocator_unit
// first-fit slot allocator over 32 pages of 8 slots with a page-full summary
//
//   channel   dir  payload                 meaning
//   in_chan   in   func, free_slot         allocate, or free a slot
//   out_chan  out  slot, status            slot index and completion code
//
// free and out-of-range requests are answered from the queue pop, via the result register;
// allocate leaves the queue, scans the summary one 8-page group per step (ST_SCAN) and
// then updates the occupancy row (ST_ROW); a failed allocate answers after the last group
// reset (synchronous, rst_n low) clears both maps and the request queue
// a two-entry queue keeps taking requests while a result waits on out_chan
// ----------------------------------------------------------------------------
module two_level_bitmap_slot_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  tlba_in_if.sink    in_chan,
  tlba_out_if.source out_chan
);
  import tlba_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_item;

  tlba_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  tlba_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == STATUS_NO_SLOT) |-> out_chan.slot == 8'd0)
    else $error("no-slot result carries a nonzero slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.status == STATUS_DONE ||
                        out_chan.status == STATUS_NO_SLOT ||
                        out_chan.status == STATUS_RANGE))
    else $error("undefined status code");

  a_pop_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_chan.valid)
    else $error("request started while a result is pending");

endmodule

[rtl/tlba_front.sv]
// ----------------------------------------------------------------------------
// tlba_front
// request intake: classifies each request and queues it in a two-entry fifo
// ----------------------------------------------------------------------------
module tlba_front (
  input  logic          clk,
  input  logic          rst_n,
  tlba_in_if.sink       in_chan,
  output logic          q_valid,
  output tlba_pkg::req_t q_item,
  input  logic          q_pop
);
  import tlba_pkg::*;

  req_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  req_t       cls;

  always_comb begin
    cls.slot = in_chan.free_slot;
    if (in_chan.func == FUNC_ALLOC) begin
      cls.op = OP_ALLOC;
    end else if (int'(in_chan.free_slot[7:3]) < USABLE_PAGES) begin
      cls.op = OP_FREE;
    end else begin
      cls.op = OP_RANGE;
    end
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (cnt_r != 2'd0);
  assign q_item        = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

[rtl/tlba_back.sv]
// ----------------------------------------------------------------------------
// tlba_back
// executes queued requests on the summary and occupancy maps
// ----------------------------------------------------------------------------
module tlba_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  tlba_pkg::req_t q_item,
  output logic           q_pop,
  tlba_out_if.source     out_chan
);
  import tlba_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [GRP_W-1:0]    grp_r, grp_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [7:0]          map_r [SUM_BITS];
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_slot_r, out_slot_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                map_we;
  logic [PAGE_W-1:0]   rd_page;
  logic [7:0]          row;
  logic [7:0]          map_wd;
  logic [PAGE_W-1:0]   fpage;
  logic [7:0]          grp_bits;
  logic [2:0]          off;

  assign fpage    = PAGE_W'(q_item.slot[7:3]);
  assign rd_page  = (state_r == ST_IDLE) ? fpage : page_r;
  assign row      = map_r[rd_page];
  assign grp_bits = sum_r[grp_r*8 +: 8];
  assign q_pop    = (state_r == ST_IDLE) && q_valid && !out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    grp_nxt        = grp_r;
    page_nxt       = page_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    map_we         = 1'b0;
    map_wd         = row;
    off            = first_zero(row);
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_item.op)
            OP_FREE: begin
              map_we         = 1'b1;
              map_wd         = row & ~(8'b1 << q_item.slot[2:0]);
              sum_nxt[fpage] = 1'b0;
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = q_item.slot;
              out_status_nxt = STATUS_DONE;
            end
            OP_RANGE: begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = q_item.slot;
              out_status_nxt = STATUS_RANGE;
            end
            default: begin
              grp_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (grp_bits != 8'hFF) begin
          page_nxt  = PAGE_W'({grp_r, first_zero(grp_bits)});
          state_nxt = ST_ROW;
        end else if (int'(grp_r) == GROUPS - 1) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = 8'd0;
          out_status_nxt = STATUS_NO_SLOT;
          state_nxt      = ST_IDLE;
        end else begin
          grp_nxt = grp_r + GRP_W'(1);
        end
      end
      ST_ROW: begin
        map_we = 1'b1;
        map_wd = row | (8'b1 << off);
        if ((row | (8'b1 << off)) == 8'hFF) begin
          sum_nxt[page_r] = 1'b1;
        end
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = 8'({page_r, off});
        out_status_nxt = STATUS_DONE;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grp_r       <= '0;
      page_r      <= '0;
      sum_r       <= sum_pad();
      out_valid_r <= 1'b0;
      for (int i = 0; i < SUM_BITS; i++) begin
        map_r[i] <= 8'd0;
      end
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      page_r      <= page_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (map_we) begin
        map_r[rd_page] <= map_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.slot   = out_slot_r;
  assign out_chan.status = out_status_r;

endmodule
